>>> src/rpvi_pkg.sv
package rpvi_pkg;

  localparam int unsigned CordicIters = 16;
  localparam logic signed [33:0] CordicK = 34'sd652032874;

  typedef enum logic [5:0] {
    S_IDLE,
    S_CORD_EL,
    S_CORD_AZ,
    S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8, S_M9, S_M10,
    S_DIV_X, S_DIV_Y, S_DIV_Z,
    S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7,
    S_P8, S_P9, S_P10, S_P11, S_P12, S_P13, S_P14,
    S_FIN
  } rpvi_state_t;

  // arctan(2^-i) in 2^-32 turn
  function automatic logic [29:0] atan_val(input logic [3:0] i);
    logic [29:0] v;
    case (i)
      4'd0:    v = 30'd536870912;
      4'd1:    v = 30'd316933406;
      4'd2:    v = 30'd167458907;
      4'd3:    v = 30'd85004756;
      4'd4:    v = 30'd42667331;
      4'd5:    v = 30'd21354465;
      4'd6:    v = 30'd10679838;
      4'd7:    v = 30'd5340245;
      4'd8:    v = 30'd2670163;
      4'd9:    v = 30'd1335087;
      4'd10:   v = 30'd667544;
      4'd11:   v = 30'd333772;
      4'd12:   v = 30'd166886;
      4'd13:   v = 30'd83443;
      4'd14:   v = 30'd41722;
      4'd15:   v = 30'd20861;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

>>> src/rpvi_cordic.sv
module rpvi_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [15:0]        angle,
  output logic               done,
  output logic signed [17:0] cos_q16,
  output logic signed [17:0] sin_q16
);
  import rpvi_pkg::*;

  logic signed [33:0] x, y, z;
  logic [1:0]         quad;
  logic [3:0]         cnt;
  logic               busy;
  logic signed [33:0] dx, dy, xr, yr;
  logic signed [17:0] cc, ss;

  assign dx = y >>> cnt;
  assign dy = x >>> cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'(CordicIters - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= CordicK;
      y    <= '0;
      z    <= 34'($signed({4'b0, angle[13:0], 16'b0}));
      quad <= angle[15:14];
    end else if (busy) begin
      if (!z[33]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - 34'($signed({4'b0, atan_val(cnt)}));
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + 34'($signed({4'b0, atan_val(cnt)}));
      end
    end
  end

  // round to Q.16 then fold back into the full circle
  assign xr = x + 34'sd8192;
  assign yr = y + 34'sd8192;
  assign cc = xr[31:14];
  assign ss = yr[31:14];

  always_comb begin
    case (quad)
      2'd0:    begin cos_q16 = cc;  sin_q16 = ss;  end
      2'd1:    begin cos_q16 = -ss; sin_q16 = cc;  end
      2'd2:    begin cos_q16 = -cc; sin_q16 = -ss; end
      default: begin cos_q16 = ss;  sin_q16 = -cc; end
    endcase
  end

endmodule

>>> src/rpvi_divider.sv
module rpvi_divider (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [35:0] num,
  input  logic [31:0]        den,
  output logic               done,
  output logic signed [36:0] quo
);
  import rpvi_pkg::*;

  localparam int unsigned NumBits = 36;
  localparam int unsigned Steps   = NumBits / 2;

  logic [NumBits-1:0] dvd, q, mag;
  logic [32:0]        rem;
  logic [31:0]        den_r;
  logic               neg;
  logic [4:0]         cnt;
  logic               busy;
  logic [32:0]        r1, r1n, r2, r2n;
  logic               ge1, ge2;

  assign mag = num[35] ? 36'(-num) : 36'(num);

  always_comb begin
    r1  = {rem[31:0], dvd[NumBits-1]};
    ge1 = r1 >= {1'b0, den_r};
    r1n = ge1 ? r1 - {1'b0, den_r} : r1;
    r2  = {r1n[31:0], dvd[NumBits-2]};
    ge2 = r2 >= {1'b0, den_r};
    r2n = ge2 ? r2 - {1'b0, den_r} : r2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(Steps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // add half the divisor for round half away from zero
      dvd   <= mag + 36'(den >> 1);
      den_r <= den;
      neg   <= num[35];
      rem   <= '0;
      q     <= '0;
    end else if (busy) begin
      dvd <= {dvd[NumBits-3:0], 2'b00};
      rem <= r2n;
      q   <= {q[NumBits-3:0], ge1, ge2};
    end
  end

  assign quo = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});

endmodule

>>> src/radar_plot_velocity_init.sv
// Each accepted item runs two CORDIC passes (elevation, azimuth), the steps S_M1 to
// S_M10, three radix-4 divisions, the steps S_P1 to S_P14 and one output step.
// Restart and first-plot items end after S_M7 with no result; a bad interval goes on to the
// output step with zero velocity. A new item is taken only once the block is idle again,
// later while a stalled earlier result holds the output register; in_stall is high during work.
// Reset (rst, synchronous): idle, no previous plot, damping 328, no result.
module radar_plot_velocity_init (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [12:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [19:0]        range,
  input  logic [15:0]        elevation,
  input  logic [15:0]        azimuth,
  input  logic signed [17:0] radial_velocity,
  input  logic [31:0]        timestamp_ms,
  input  logic               restart,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] vel_x,
  output logic signed [23:0] vel_y,
  output logic signed [23:0] vel_z,
  output logic               bad_interval
);
  import rpvi_pkg::*;

  rpvi_state_t state, state_next;

  logic [12:0]        damping;
  logic signed [21:0] prev_x, prev_y, prev_z;
  logic [31:0]        prev_time;
  logic               have_prev;

  logic [19:0]        rng_r;
  logic [15:0]        maz_r;
  logic signed [17:0] rv_r;
  logic [31:0]        t_r, dt;
  logic               restart_r, bad;

  logic signed [17:0] ce, se, ca, sa, ex, ey, ez;
  logic signed [39:0] rce;
  logic signed [21:0] px, py, pz;
  logic signed [35:0] nx, ny, nz;
  logic signed [36:0] vx, vy, vz;
  logic signed [59:0] acc;
  logic signed [39:0] vr, tx, ty, tz;
  logic signed [41:0] rx, ry, rz;

  logic signed [39:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [57:0] prod;
  logic signed [57:0] prod_r16, prod_r12, prod_r32;
  logic signed [59:0] acc_sum, acc_r16;

  logic               cord_start, cord_done;
  logic [15:0]        cord_angle;
  logic signed [17:0] cord_c, cord_s;
  logic               div_start, div_done;
  logic signed [35:0] div_num;
  logic signed [36:0] div_quo;

  logic accept, out_load;

  rpvi_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cord_start),
    .angle   (cord_angle),
    .done    (cord_done),
    .cos_q16 (cord_c),
    .sin_q16 (cord_s)
  );

  rpvi_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (dt),
    .done  (div_done),
    .quo   (div_quo)
  );

  function automatic logic signed [23:0] sat24(input logic signed [41:0] v);
    if (v > 42'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -42'sd8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign out_load  = (state == S_FIN) && (!out_valid || !out_stall);

  assign prod_r32 = prod + 58'sd2147483648;
  assign prod_r16 = prod + 58'sd32768;
  assign prod_r12 = prod + 58'sd2048;
  assign acc_sum  = acc + 60'(prod);
  assign acc_r16  = acc_sum + 60'sd32768;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (accept) state_next = S_CORD_EL;
      S_CORD_EL: if (cord_done) state_next = S_CORD_AZ;
      S_CORD_AZ: if (cord_done) state_next = S_M1;
      S_M1:      state_next = S_M2;
      S_M2:      state_next = S_M3;
      S_M3:      state_next = S_M4;
      S_M4:      state_next = S_M5;
      S_M5:      state_next = S_M6;
      S_M6:      state_next = S_M7;
      S_M7: begin
        if (restart_r || !have_prev) begin
          state_next = S_IDLE;
        end else if (t_r <= prev_time) begin
          state_next = S_FIN;
        end else begin
          state_next = S_M8;
        end
      end
      S_M8:      state_next = S_M9;
      S_M9:      state_next = S_M10;
      S_M10:     state_next = S_DIV_X;
      S_DIV_X:   if (div_done) state_next = S_DIV_Y;
      S_DIV_Y:   if (div_done) state_next = S_DIV_Z;
      S_DIV_Z:   if (div_done) state_next = S_P1;
      S_P1:      state_next = S_P2;
      S_P2:      state_next = S_P3;
      S_P3:      state_next = S_P4;
      S_P4:      state_next = S_P5;
      S_P5:      state_next = S_P6;
      S_P6:      state_next = S_P7;
      S_P7:      state_next = S_P8;
      S_P8:      state_next = S_P9;
      S_P9:      state_next = S_P10;
      S_P10:     state_next = S_P11;
      S_P11:     state_next = S_P12;
      S_P12:     state_next = S_P13;
      S_P13:     state_next = S_P14;
      S_P14:     state_next = S_FIN;
      S_FIN:     if (out_load) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // sequencer outputs: input stall, unit starts and operands, multiplier operands
  always_comb begin
    in_stall   = (state != S_IDLE);
    cord_start = 1'b0;
    cord_angle = maz_r;
    div_start  = 1'b0;
    div_num    = nx;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      S_IDLE: begin
        cord_start = accept;
        cord_angle = elevation;
      end
      S_CORD_EL: cord_start = cord_done;
      S_M1:  begin mul_a = 40'($signed({1'b0, rng_r})); mul_b = ce; end
      S_M2:  begin mul_a = prod[39:0]; mul_b = ca; end
      S_M3:  begin mul_a = rce; mul_b = sa; end
      S_M4:  begin mul_a = 40'($signed({1'b0, rng_r})); mul_b = se; end
      S_M5:  begin mul_a = 40'(ce); mul_b = ca; end
      S_M6:  begin mul_a = 40'(ce); mul_b = sa; end
      S_M7:  begin mul_a = 40'(px) - 40'(prev_x); mul_b = 18'sd4000; end
      S_M8:  begin mul_a = 40'(py) - 40'(prev_y); mul_b = 18'sd4000; end
      S_M9:  begin mul_a = 40'(pz) - 40'(prev_z); mul_b = 18'sd4000; end
      S_M10: begin div_start = 1'b1; div_num = nx; end
      S_DIV_X: begin div_start = div_done; div_num = ny; end
      S_DIV_Y: begin div_start = div_done; div_num = nz; end
      S_P1:  begin mul_a = 40'(vx); mul_b = ex; end
      S_P2:  begin mul_a = 40'(vy); mul_b = ey; end
      S_P3:  begin mul_a = 40'(vz); mul_b = ez; end
      S_P5:  begin mul_a = vr; mul_b = ex; end
      S_P6:  begin mul_a = vr; mul_b = ey; end
      S_P7:  begin mul_a = vr; mul_b = ez; end
      S_P8:  begin mul_a = 40'(rv_r); mul_b = ex; end
      S_P9:  begin mul_a = 40'(rv_r); mul_b = ey; end
      S_P10: begin mul_a = 40'(rv_r); mul_b = ez; end
      S_P11: begin mul_a = tx; mul_b = $signed({5'b0, damping}); end
      S_P12: begin mul_a = ty; mul_b = $signed({5'b0, damping}); end
      S_P13: begin mul_a = tz; mul_b = $signed({5'b0, damping}); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      damping   <= 13'd328;
      prev_x    <= '0;
      prev_y    <= '0;
      prev_z    <= '0;
      prev_time <= '0;
      have_prev <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) damping <= cfg_data;
      // commit this plot as the previous one once the differences are formed
      if ((state == S_M7 && (restart_r || !have_prev || t_r <= prev_time)) ||
          state == S_M10) begin
        prev_x    <= px;
        prev_y    <= py;
        prev_z    <= pz;
        prev_time <= t_r;
        have_prev <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (accept) begin
      rng_r     <= range;
      maz_r     <= 16'(16'd16384 - azimuth);
      rv_r      <= radial_velocity;
      t_r       <= timestamp_ms;
      restart_r <= restart;
    end
    case (state)
      S_CORD_EL: if (cord_done) begin ce <= cord_c; se <= cord_s; end
      S_CORD_AZ: if (cord_done) begin ca <= cord_c; sa <= cord_s; end
      S_M2:  rce <= prod[39:0];
      S_M3:  px  <= prod_r32[53:32];
      S_M4:  py  <= prod_r32[53:32];
      S_M5:  pz  <= prod_r16[37:16];
      S_M6:  ex  <= prod_r16[33:16];
      S_M7: begin
        ey  <= prod_r16[33:16];
        ez  <= se;
        dt  <= t_r - prev_time;
        bad <= (t_r <= prev_time);
      end
      S_M8:  nx <= prod[35:0];
      S_M9:  ny <= prod[35:0];
      S_M10: nz <= prod[35:0];
      S_DIV_X: if (div_done) vx <= div_quo;
      S_DIV_Y: if (div_done) vy <= div_quo;
      S_DIV_Z: if (div_done) vz <= div_quo;
      S_P2:  acc <= 60'(prod);
      S_P3:  acc <= acc_sum;
      S_P4:  vr  <= acc_r16[55:16];
      S_P6:  tx  <= 40'(vx) - prod_r16[55:16];
      S_P7:  ty  <= 40'(vy) - prod_r16[55:16];
      S_P8:  tz  <= 40'(vz) - prod_r16[55:16];
      S_P9:  rx  <= prod_r16[57:16];
      S_P10: ry  <= prod_r16[57:16];
      S_P11: rz  <= prod_r16[57:16];
      S_P12: rx  <= rx + prod_r12[53:12];
      S_P13: ry  <= ry + prod_r12[53:12];
      S_P14: rz  <= rz + prod_r12[53:12];
      default: ;
    endcase
    if (out_load) begin
      bad_interval <= bad;
      vel_x        <= bad ? 24'sd0 : sat24(rx);
      vel_y        <= bad ? 24'sd0 : sat24(ry);
      vel_z        <= bad ? 24'sd0 : sat24(rz);
    end
  end

endmodule

>>> src/rpvi_checker.sv
module rpvi_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [23:0] vel_x,
  input logic signed [23:0] vel_y,
  input logic signed [23:0] vel_z,
  input logic               bad_interval
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // an accepted item keeps the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after an item");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_interval |-> vel_x == 0 && vel_y == 0 && vel_z == 0)
    else $error("bad interval with nonzero velocity");

  // a new result comes only out of a busy period
  a_rise_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in progress");

endmodule

bind radar_plot_velocity_init rpvi_checker u_rpvi_checker (.*);
